// ----- src/lctw_pkg.sv -----
`timescale 1ns / 1ps

package lctw_pkg;

	localparam int unsigned COL_W = 5;
	localparam logic [COL_W-1:0] COLUMNS = 5'd16;

	localparam int unsigned BIN_W = 32;
	localparam int unsigned DEC_DIGITS = 10;
	localparam int unsigned BCD_W = 4 * DEC_DIGITS;
	localparam logic [3:0] DEC_COUNT = 4'd10;
	localparam logic [3:0] HEX_COUNT = 4'd8;

	localparam logic [7:0] CMD_CLEAR = 8'h01;
	localparam logic [7:0] CMD_HOME = 8'h02;
	localparam logic [7:0] CMD_LINE2 = 8'hC0;
	localparam logic [7:0] CMD_ENTRY = 8'h06;
	localparam logic [7:0] CMD_LEFT = 8'h10;
	localparam logic [7:0] CMD_RIGHT = 8'h14;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_A = 8'h41;

	typedef enum logic [2:0] {
		OP_CLEAR = 3'd0,
		OP_HOME = 3'd1,
		OP_PUT = 3'd2,
		OP_MOVE = 3'd3,
		OP_DEC = 3'd4,
		OP_HEX = 3'd5
	} op_t;

	typedef logic [3:0] step_t;

	localparam step_t ST_IDLE = 4'd0;
	localparam step_t ST_CLR1 = 4'd1;
	localparam step_t ST_CLR2 = 4'd2;
	localparam step_t ST_HOME = 4'd3;
	localparam step_t ST_PUT_CHK = 4'd4;
	localparam step_t ST_PUT_DATA = 4'd5;
	localparam step_t ST_PUT_ENTRY = 4'd6;
	localparam step_t ST_MOVE_CHK = 4'd7;
	localparam step_t ST_MOVE = 4'd8;
	localparam step_t ST_DEC_LOAD = 4'd9;
	localparam step_t ST_DABBLE = 4'd10;
	localparam step_t ST_SKIP = 4'd11;
	localparam step_t ST_DIG_CHK = 4'd12;
	localparam step_t ST_DIG_DATA = 4'd13;
	localparam step_t ST_DIG_ENTRY = 4'd14;
	localparam step_t ST_HEX_LOAD = 4'd15;

	typedef enum logic [2:0] {
		EMIT_NONE = 3'd0,
		EMIT_CMD = 3'd1,
		EMIT_HOME = 3'd2,
		EMIT_MOVE = 3'd3,
		EMIT_CHAR = 3'd4,
		EMIT_DIGIT = 3'd5
	} emit_t;

	typedef enum logic [1:0] {
		LAST_NO = 2'd0,
		LAST_YES = 2'd1,
		LAST_DIGIT = 2'd2
	} last_t;

	typedef enum logic [1:0] {
		COL_KEEP = 2'd0,
		COL_ZERO = 2'd1,
		COL_INC = 2'd2,
		COL_MOVE = 2'd3
	} col_op_t;

	typedef enum logic [2:0] {
		DP_NONE = 3'd0,
		DP_LOAD_DEC = 3'd1,
		DP_DABBLE = 3'd2,
		DP_LOAD_HEX = 3'd3,
		DP_SKIP = 3'd4,
		DP_NEXT = 3'd5
	} dp_op_t;

	typedef enum logic [2:0] {
		COND_ALWAYS = 3'd0,
		COND_DISPATCH = 3'd1,
		COND_COL_FULL = 3'd2,
		COND_MOVE_BLOCKED = 3'd3,
		COND_BITS_LEFT = 3'd4,
		COND_LEAD_ZERO = 3'd5,
		COND_MORE_DIGITS = 3'd6
	} cond_t;

	typedef struct packed {
		emit_t emit;
		logic [7:0] cmd;
		last_t last;
		col_op_t col_op;
		dp_op_t dp_op;
		cond_t cond;
		step_t tgt_t;
		step_t tgt_f;
	} ucode_t;

	typedef struct packed {
		ucode_t word;
		logic fire;
		logic accept;
	} ctrl_t;

	typedef struct packed {
		logic col_full;
		logic move_blocked;
		logic bits_left;
		logic lead_zero;
		logic more_digits;
		logic out_busy;
	} status_t;

	function automatic ucode_t mk(emit_t emit, logic [7:0] cmd, last_t last, col_op_t col_op,
			dp_op_t dp_op, cond_t cond, step_t tgt_t, step_t tgt_f);
		ucode_t w;
		w.emit = emit;
		w.cmd = cmd;
		w.last = last;
		w.col_op = col_op;
		w.dp_op = dp_op;
		w.cond = cond;
		w.tgt_t = tgt_t;
		w.tgt_f = tgt_f;
		return w;
	endfunction

	function automatic ucode_t ucode(step_t pc);
		ucode_t w;
		unique case (pc)
			ST_IDLE: w = mk(EMIT_NONE, 8'h00, LAST_NO, COL_KEEP, DP_NONE,
				COND_DISPATCH, ST_IDLE, ST_IDLE);
			ST_CLR1: w = mk(EMIT_CMD, CMD_CLEAR, LAST_NO, COL_KEEP, DP_NONE,
				COND_ALWAYS, ST_CLR2, ST_CLR2);
			ST_CLR2: w = mk(EMIT_CMD, CMD_HOME, LAST_YES, COL_ZERO, DP_NONE,
				COND_ALWAYS, ST_IDLE, ST_IDLE);
			ST_HOME: w = mk(EMIT_HOME, 8'h00, LAST_YES, COL_ZERO, DP_NONE,
				COND_ALWAYS, ST_IDLE, ST_IDLE);
			ST_PUT_CHK: w = mk(EMIT_NONE, 8'h00, LAST_NO, COL_KEEP, DP_NONE,
				COND_COL_FULL, ST_IDLE, ST_PUT_DATA);
			ST_PUT_DATA: w = mk(EMIT_CHAR, 8'h00, LAST_NO, COL_KEEP, DP_NONE,
				COND_ALWAYS, ST_PUT_ENTRY, ST_PUT_ENTRY);
			ST_PUT_ENTRY: w = mk(EMIT_CMD, CMD_ENTRY, LAST_YES, COL_INC, DP_NONE,
				COND_ALWAYS, ST_IDLE, ST_IDLE);
			ST_MOVE_CHK: w = mk(EMIT_NONE, 8'h00, LAST_NO, COL_KEEP, DP_NONE,
				COND_MOVE_BLOCKED, ST_IDLE, ST_MOVE);
			ST_MOVE: w = mk(EMIT_MOVE, 8'h00, LAST_YES, COL_MOVE, DP_NONE,
				COND_ALWAYS, ST_IDLE, ST_IDLE);
			ST_DEC_LOAD: w = mk(EMIT_NONE, 8'h00, LAST_NO, COL_KEEP, DP_LOAD_DEC,
				COND_ALWAYS, ST_DABBLE, ST_DABBLE);
			ST_DABBLE: w = mk(EMIT_NONE, 8'h00, LAST_NO, COL_KEEP, DP_DABBLE,
				COND_BITS_LEFT, ST_DABBLE, ST_SKIP);
			ST_SKIP: w = mk(EMIT_NONE, 8'h00, LAST_NO, COL_KEEP, DP_SKIP,
				COND_LEAD_ZERO, ST_SKIP, ST_DIG_CHK);
			ST_DIG_CHK: w = mk(EMIT_NONE, 8'h00, LAST_NO, COL_KEEP, DP_NONE,
				COND_COL_FULL, ST_IDLE, ST_DIG_DATA);
			ST_DIG_DATA: w = mk(EMIT_DIGIT, 8'h00, LAST_NO, COL_KEEP, DP_NONE,
				COND_ALWAYS, ST_DIG_ENTRY, ST_DIG_ENTRY);
			ST_DIG_ENTRY: w = mk(EMIT_CMD, CMD_ENTRY, LAST_DIGIT, COL_INC, DP_NEXT,
				COND_MORE_DIGITS, ST_DIG_CHK, ST_IDLE);
			ST_HEX_LOAD: w = mk(EMIT_NONE, 8'h00, LAST_NO, COL_KEEP, DP_LOAD_HEX,
				COND_ALWAYS, ST_SKIP, ST_SKIP);
		endcase
		return w;
	endfunction

	function automatic step_t entry(logic [2:0] opcode);
		step_t s;
		priority case (opcode)
			OP_CLEAR: s = ST_CLR1;
			OP_HOME: s = ST_HOME;
			OP_PUT: s = ST_PUT_CHK;
			OP_MOVE: s = ST_MOVE_CHK;
			OP_DEC: s = ST_DEC_LOAD;
			OP_HEX: s = ST_HEX_LOAD;
			default: s = ST_IDLE;
		endcase
		return s;
	endfunction

endpackage

// ----- src/lctw_sequencer.sv -----
`timescale 1ns / 1ps

module lctw_sequencer (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [2:0] opcode,
	input lctw_pkg::status_t status,
	output lctw_pkg::ctrl_t ctrl
);

	lctw_pkg::step_t pc_q;
	lctw_pkg::step_t pc_d;
	lctw_pkg::ucode_t word;
	logic cond_true;
	logic stall;
	logic accept;

	assign word = lctw_pkg::ucode(pc_q);
	assign in_ready = (pc_q == lctw_pkg::ST_IDLE);
	assign accept = in_valid && in_ready;
	assign stall = (word.emit != lctw_pkg::EMIT_NONE) && status.out_busy;

	always_comb begin
		unique case (word.cond)
			lctw_pkg::COND_ALWAYS: cond_true = 1'b1;
			lctw_pkg::COND_DISPATCH: cond_true = accept;
			lctw_pkg::COND_COL_FULL: cond_true = status.col_full;
			lctw_pkg::COND_MOVE_BLOCKED: cond_true = status.move_blocked;
			lctw_pkg::COND_BITS_LEFT: cond_true = status.bits_left;
			lctw_pkg::COND_LEAD_ZERO: cond_true = status.lead_zero;
			lctw_pkg::COND_MORE_DIGITS: cond_true = status.more_digits;
			default: cond_true = 1'b0;
		endcase
	end

	always_comb begin
		pc_d = pc_q;
		if (word.cond == lctw_pkg::COND_DISPATCH) begin
			pc_d = accept ? lctw_pkg::entry(opcode) : lctw_pkg::ST_IDLE;
		end else if (!stall) begin
			pc_d = cond_true ? word.tgt_t : word.tgt_f;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= lctw_pkg::ST_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	assign ctrl.word = word;
	assign ctrl.fire = !stall;
	assign ctrl.accept = accept;

endmodule

// ----- src/lctw_datapath.sv -----
`timescale 1ns / 1ps

module lctw_datapath (
	input logic clk,
	input logic arst_n,
	input lctw_pkg::ctrl_t ctrl,
	output lctw_pkg::status_t status,
	input logic [7:0] char_code,
	input logic line_select,
	input logic move_right,
	input logic [31:0] number,
	output logic out_valid,
	input logic out_ready,
	output logic [7:0] lcd_byte,
	output logic is_data,
	output logic last
);

	logic [7:0] ch_q;
	logic line_q;
	logic right_q;
	logic [lctw_pkg::COL_W-1:0] col_q;
	logic [lctw_pkg::COL_W-1:0] col_inc;
	logic [lctw_pkg::BCD_W-1:0] bcd_q;
	logic [lctw_pkg::BCD_W-1:0] bcd_adj;
	logic [lctw_pkg::BIN_W-1:0] bin_q;
	logic [4:0] bit_q;
	logic [3:0] cnt_q;
	logic [3:0] digit;
	logic [7:0] digit_char;
	logic [7:0] byte_d;
	logic last_d;
	logic emit;
	logic out_valid_q;
	logic [7:0] lcd_byte_q;
	logic is_data_q;
	logic last_q;

	assign col_inc = col_q + 5'd1;
	assign digit = bcd_q[lctw_pkg::BCD_W-1 -: 4];
	assign digit_char = (digit < 4'd10) ? (lctw_pkg::CHAR_ZERO + {4'h0, digit})
		: (lctw_pkg::CHAR_A + {4'h0, digit} - 8'd10);

	assign status.col_full = (col_q >= lctw_pkg::COLUMNS);
	assign status.move_blocked = right_q ? (col_q >= lctw_pkg::COLUMNS) : (col_q == '0);
	assign status.bits_left = (bit_q != 5'd0);
	assign status.more_digits = (cnt_q > 4'd1);
	assign status.lead_zero = (digit == 4'd0) && (cnt_q > 4'd1);
	assign status.out_busy = out_valid_q && !out_ready;

	always_comb begin
		bcd_adj = bcd_q;
		for (int i = 0; i < lctw_pkg::DEC_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end
		end
	end

	always_comb begin
		unique case (ctrl.word.emit)
			lctw_pkg::EMIT_CMD: byte_d = ctrl.word.cmd;
			lctw_pkg::EMIT_HOME: byte_d = line_q ? lctw_pkg::CMD_LINE2 : lctw_pkg::CMD_HOME;
			lctw_pkg::EMIT_MOVE: byte_d = right_q ? lctw_pkg::CMD_RIGHT : lctw_pkg::CMD_LEFT;
			lctw_pkg::EMIT_CHAR: byte_d = ch_q;
			lctw_pkg::EMIT_DIGIT: byte_d = digit_char;
			default: byte_d = 8'h00;
		endcase
		unique case (ctrl.word.last)
			lctw_pkg::LAST_YES: last_d = 1'b1;
			lctw_pkg::LAST_DIGIT: last_d = !status.more_digits || (col_inc >= lctw_pkg::COLUMNS);
			default: last_d = 1'b0;
		endcase
	end

	assign emit = ctrl.fire && (ctrl.word.emit != lctw_pkg::EMIT_NONE);

	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			ch_q <= char_code;
			line_q <= line_select;
			right_q <= move_right;
		end
		if (emit) begin
			lcd_byte_q <= byte_d;
			is_data_q <= (ctrl.word.emit == lctw_pkg::EMIT_CHAR)
				|| (ctrl.word.emit == lctw_pkg::EMIT_DIGIT);
			last_q <= last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			out_valid_q <= 1'b0;
			bcd_q <= '0;
			bin_q <= '0;
			bit_q <= '0;
			cnt_q <= '0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (ctrl.fire) begin
				unique case (ctrl.word.col_op)
					lctw_pkg::COL_ZERO: col_q <= '0;
					lctw_pkg::COL_INC: col_q <= col_inc;
					lctw_pkg::COL_MOVE: col_q <= right_q ? col_inc : (col_q - 5'd1);
					default: col_q <= col_q;
				endcase
			end
			if (ctrl.accept) begin
				bin_q <= number;
			end else if (ctrl.fire) begin
				unique case (ctrl.word.dp_op)
					lctw_pkg::DP_LOAD_DEC: begin
						bcd_q <= '0;
						bit_q <= 5'(lctw_pkg::BIN_W - 1);
						cnt_q <= lctw_pkg::DEC_COUNT;
					end
					lctw_pkg::DP_DABBLE: begin
						bcd_q <= {bcd_adj[lctw_pkg::BCD_W-2:0], bin_q[lctw_pkg::BIN_W-1]};
						bin_q <= {bin_q[lctw_pkg::BIN_W-2:0], 1'b0};
						bit_q <= bit_q - 5'd1;
					end
					lctw_pkg::DP_LOAD_HEX: begin
						bcd_q <= {bin_q, 8'h00};
						cnt_q <= lctw_pkg::HEX_COUNT;
					end
					lctw_pkg::DP_SKIP, lctw_pkg::DP_NEXT: begin
						if ((ctrl.word.dp_op == lctw_pkg::DP_NEXT) || status.lead_zero) begin
							bcd_q <= {bcd_q[lctw_pkg::BCD_W-5:0], 4'h0};
							cnt_q <= cnt_q - 4'd1;
						end
					end
					default: begin
						bcd_q <= bcd_q;
					end
				endcase
			end
		end
	end

	assign out_valid = out_valid_q;
	assign lcd_byte = lcd_byte_q;
	assign is_data = is_data_q;
	assign last = last_q;

endmodule

// ----- src/char_lcd_text_command_writer.sv -----
`timescale 1ns / 1ps

// Turns text requests for a two-line character LCD into command and data bytes.
// The input channel (in_valid/in_ready) takes one request with its opcode and
// operands; the output channel (out_valid/out_ready) gives one byte per
// transfer, with is_data as register select and last on the final byte of a
// request. A request that produces no byte raises no last.
// A microcode sequencer steps through a 16-word control table and drives the
// cursor, digit and output registers. One request is handled at a time, and
// in_ready is high only while the sequencer sits in its idle step.
// Clear emits a clear and a home command; home emits one address command for
// the selected line; put char emits the character and an entry-mode command,
// and move one shift command, unless the cursor is at the edge. Decimal
// printing takes a load step and a binary-to-BCD conversion, then skips leading
// zeros and emits each shown digit followed by an entry-mode command, while the
// row has room; hex takes a load step instead of the conversion.
// When the receiver holds out_ready low, the output register keeps its byte and
// the sequencer waits at its next emitting step. Reset returns the cursor to
// column zero, empties the output register and puts the sequencer in idle.
module char_lcd_text_command_writer (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [2:0] opcode,
	input logic [7:0] char_code,
	input logic line_select,
	input logic move_right,
	input logic [31:0] number,
	output logic out_valid,
	input logic out_ready,
	output logic [7:0] lcd_byte,
	output logic is_data,
	output logic last
);

	lctw_pkg::ctrl_t ctrl;
	lctw_pkg::status_t status;

	lctw_sequencer u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.status(status),
		.ctrl(ctrl)
	);

	lctw_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(ctrl),
		.status(status),
		.char_code(char_code),
		.line_select(line_select),
		.move_right(move_right),
		.number(number),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.lcd_byte(lcd_byte),
		.is_data(is_data),
		.last(last)
	);

endmodule

// ----- src/lctw_assert.sv -----
`timescale 1ns / 1ps

module lctw_assert (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic [2:0] opcode,
	input logic out_valid,
	input logic out_ready,
	input logic [7:0] lcd_byte,
	input logic is_data,
	input logic last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(lcd_byte) && $stable(is_data)
			&& $stable(last))
		else $error("output byte changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (opcode <= lctw_pkg::OP_HEX) |=> !in_ready)
		else $error("request channel stayed open after a valid request");

	a_data_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_data |-> !last)
		else $error("data byte flagged as last");

	a_idle_pending_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && out_valid |-> last)
		else $error("idle with a non-final byte pending");

endmodule

bind char_lcd_text_command_writer lctw_assert u_lctw_assert (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.opcode(opcode),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.lcd_byte(lcd_byte),
	.is_data(is_data),
	.last(last)
);
